/* hw/rtl/gffrp_pkg.sv */
// ----------------------------------------------------------------------------
// gffrp_pkg
// types and constants shared by the grid rectangle packer
// ----------------------------------------------------------------------------
package gffrp_pkg;

  localparam int unsigned FieldW = 5;

  typedef struct packed {
    logic [FieldW-1:0] item_width;
    logic [FieldW-1:0] item_height;
    logic              last_item;
  } gffrp_in_t;

  typedef struct packed {
    logic fits;
    logic overflow;
  } gffrp_out_t;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } gffrp_cfg_e;

endpackage

/* hw/rtl/grid_first_fit_rect_packer.sv */
// ----------------------------------------------------------------------------
// grid_first_fit_rect_packer
// stores rectangles, sorts largest first and places them first-fit on a grid
// ----------------------------------------------------------------------------
// channel | dir | signals                           | payload
// in      | in  | in_valid_i  / in_ready_o          | gffrp_in_t
// out     | out | out_valid_o / out_ready_i         | gffrp_out_t
// cfg     | in  | cfg_valid_i / cfg_ready_o         | cfg_index_i, cfg_data_i
//
// a non-last request is stored in the list. a last request runs insertion
// sort (one compare and move per cycle through the store memory), then for
// each rectangle a fetch and a load, a test of each candidate position, and
// a check pass and a mark pass over its rows, all through one shared row
// mask unit. reset empties the list and clears the grid; the grid is also
// cleared row by row before packing. a waiting result holds in_ready_o low.
module grid_first_fit_rect_packer import gffrp_pkg::*; #(
  parameter int unsigned MAX_RECTS  = 32,
  parameter int unsigned MAX_GRID_W = 16,
  parameter int unsigned MAX_GRID_H = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gffrp_in_t         in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gffrp_out_t        out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [FieldW-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECTS + 1);
  localparam int unsigned RW = (MAX_GRID_H > 1) ? $clog2(MAX_GRID_H) : 1;
  localparam int unsigned XW = $clog2(MAX_GRID_W + 1) + 1;
  localparam int unsigned YW = $clog2(MAX_GRID_H + 1) + 1;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_SRD   = 11'b00000000010,
    ST_SCMP  = 11'b00000000100,
    ST_SPUT  = 11'b00000001000,
    ST_CLR   = 11'b00000010000,
    ST_FETCH = 11'b00000100000,
    ST_LOAD  = 11'b00001000000,
    ST_POS   = 11'b00010000000,
    ST_CHK   = 11'b00100000000,
    ST_MARK  = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [2*FieldW-1:0] mem [MAX_RECTS];
  logic [2*FieldW-1:0] rd_q;
  logic [AW-1:0]       ra, wa;
  logic [2*FieldW-1:0] wd;
  logic                we;

  logic [MAX_GRID_W-1:0] occ [MAX_GRID_H];

  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic          ovf_q, ovf_d;
  logic [FieldW-1:0] gw_q, gh_q;
  logic [2*FieldW-1:0] tmp_q, tmp_d;
  logic [FieldW-1:0] rw_q, rw_d, rh_q, rh_d;
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [YW-1:0] k_q, k_d;
  logic [RW-1:0] clr_q, clr_d;
  gffrp_out_t res_q, res_d;

  logic [XW-1:0] gwe;
  logic [YW-1:0] ghe;
  assign gwe = (32'(gw_q) > MAX_GRID_W) ? XW'(MAX_GRID_W) : XW'(gw_q);
  assign ghe = (32'(gh_q) > MAX_GRID_H) ? YW'(MAX_GRID_H) : YW'(gh_q);

  // shared unit: span mask of the current rectangle at the current column
  logic [MAX_GRID_W-1:0] span;
  logic [YW-1:0]         krow;
  logic [RW-1:0]         kidx;
  logic                  hit;
  always_comb begin
    span = '0;
    for (int b = 0; b < MAX_GRID_W; b++) begin
      if ((XW+1)'(b) >= (XW+1)'(col_q) &&
          (XW+1)'(b) < (XW+1)'(col_q) + (XW+1)'(rw_q)) begin
        span[b] = 1'b1;
      end
    end
    krow = row_q + k_q;
    kidx = krow[RW-1:0];
    hit  = |(occ[kidx] & span);
  end

  logic bigger;
  assign bigger = tmp_q > rd_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_GRID_H; r++) occ[r] <= '0;
    end else if (state_q == ST_CLR) begin
      occ[clr_q] <= '0;
    end else if (state_q == ST_MARK && k_q < YW'(rh_q)) begin
      occ[kidx] <= occ[kidx] | span;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; i_d = i_q; j_d = j_q; ovf_d = ovf_q; tmp_d = tmp_q;
    rw_d = rw_q; rh_d = rh_q; col_d = col_q; row_d = row_q; k_d = k_q;
    clr_d = clr_q; res_d = res_q;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cnt_q < CW'(MAX_RECTS)) begin
            we = 1'b1; wa = cnt_q[AW-1:0];
            wd = {in_data_i.item_width, in_data_i.item_height};
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_item) begin
            if (ovf_d) begin
              res_d = '{fits: 1'b0, overflow: 1'b1};
              state_d = ST_OUT;
            end else begin
              i_d = CW'(1);
              state_d = ST_SRD;
            end
          end
        end
      end
      ST_SRD: begin
        if (i_q >= cnt_q) begin
          clr_d = '0;
          state_d = ST_CLR;
        end else begin
          ra = i_q[AW-1:0];
          j_d = i_q;
          state_d = ST_SCMP;
        end
      end
      ST_SCMP: begin
        // first pass: rd_q holds element i, capture it as tmp
        if (j_q == i_q) begin
          tmp_d = rd_q;
        end
        ra = j_q[AW-1:0] - 1'b1;
        state_d = ST_SPUT;
      end
      ST_SPUT: begin
        if (j_q > 0 && bigger) begin
          we = 1'b1; wa = j_q[AW-1:0]; wd = rd_q;
          j_d = j_q - 1'b1;
          ra = j_q[AW-1:0] - 2'd2;
          state_d = ST_SPUT;
        end else begin
          we = 1'b1; wa = j_q[AW-1:0]; wd = tmp_q;
          i_d = i_q + 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == RW'(MAX_GRID_H - 1)) begin
          i_d = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (i_q >= cnt_q) begin
          res_d = '{fits: 1'b1, overflow: 1'b0};
          state_d = ST_OUT;
        end else begin
          ra = i_q[AW-1:0];
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rw_d = rd_q[2*FieldW-1:FieldW];
        rh_d = rd_q[FieldW-1:0];
        row_d = '0; col_d = '0;
        state_d = ST_POS;
      end
      ST_POS: begin
        k_d = '0;
        if ((YW+1)'(row_q) + (YW+1)'(rh_q) > (YW+1)'(ghe)) begin
          res_d = '{fits: 1'b0, overflow: 1'b0};
          state_d = ST_OUT;
        end else if ((XW+1)'(col_q) + (XW+1)'(rw_q) > (XW+1)'(gwe)) begin
          col_d = '0; row_d = row_q + 1'b1;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (k_q >= YW'(rh_q)) begin
          k_d = '0;
          state_d = ST_MARK;
        end else if (hit) begin
          col_d = col_q + 1'b1;
          state_d = ST_POS;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_MARK: begin
        if (k_q >= YW'(rh_q)) begin
          i_d = i_q + 1'b1;
          state_d = ST_FETCH;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          cnt_d = '0; ovf_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sput reads element j-1 while j>0; guard in the compare path above keeps
  // a stale rd_q from moving when j reaches zero

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      gw_q    <= FieldW'(16);
      gh_q    <= FieldW'(16);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GRID_WIDTH) gw_q <= cfg_data_i;
        else gh_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; tmp_q <= tmp_d;
    rw_q <= rw_d; rh_q <= rh_d; col_q <= col_d; row_q <= row_d;
    k_q <= k_d; clr_q <= clr_d; res_q <= res_d;
  end

endmodule
